// File: hdl/assert_macros.svh
// ---------------------------------------------------------------------------
// assertion macros
// shared property forms for the checker files
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled in reset
`define ASSERT_SAME(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, disabled in reset
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: hdl/spf_pkg.sv
// ---------------------------------------------------------------------------
// spf_pkg
// types and codes shared by the stateful packet filter files
// ---------------------------------------------------------------------------
package spf_pkg;

  // request kinds carried on tuser
  localparam logic [1:0] REQ_PKT_IN   = 2'd0;
  localparam logic [1:0] REQ_PKT_OUT  = 2'd1;
  localparam logic [1:0] REQ_RULE_WR  = 2'd2;
  localparam logic [1:0] REQ_CONN_ADD = 2'd3;

  // verdict codes
  localparam logic [2:0] V_DROP   = 3'd0;
  localparam logic [2:0] V_ACCEPT = 3'd1;
  localparam logic [2:0] V_MAX    = 3'd5;

  // hook codes
  localparam logic [2:0] HK_PRE  = 3'd0;
  localparam logic [2:0] HK_IN   = 3'd1;
  localparam logic [2:0] HK_FWD  = 3'd2;
  localparam logic [2:0] HK_OUT  = 3'd3;
  localparam logic [2:0] HK_POST = 3'd4;

  // configuration register indexes
  localparam logic CFG_THRESHOLD  = 1'b0;
  localparam logic CFG_RULE_COUNT = 1'b1;

  localparam logic [7:0] PROTO_TCP       = 8'd6;
  localparam int         ACK_BIT         = 4;
  localparam logic [7:0] THRESHOLD_RESET = 8'd100;

  // stream widths
  localparam int IN_DATA_W  = 128;
  localparam int OUT_DATA_W = 16;

  typedef struct packed {
    logic [31:0] src_ip;
    logic [31:0] dst_ip;
    logic [15:0] sport;
    logic [15:0] dport;
    logic [7:0]  protocol;
  } tuple_t;

  typedef struct packed {
    logic        needs_conn;
    logic [2:0]  verdict;
    logic [2:0]  stage;
    tuple_t      tup;
  } rule_t;

  // write side of the connection table
  typedef struct packed {
    logic   we;
    tuple_t tup;
  } conn_wr_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RULE_RD,
    S_RULE_CHK,
    S_CONN_RD,
    S_CONN_CHK,
    S_ADD,
    S_DONE
  } state_t;

  typedef enum logic [1:0] {
    PH_A,
    PH_B,
    PH_C
  } phase_t;

endpackage

// File: hdl/spf_conn_table.sv
// ---------------------------------------------------------------------------
// spf_conn_table
// connection tuple memory, one write port and one registered read port
// ---------------------------------------------------------------------------
module spf_conn_table #(
  parameter int CONN_ENTRIES = 256,
  parameter int CIW = (CONN_ENTRIES > 1) ? $clog2(CONN_ENTRIES) : 1
) (
  input  logic              clk,
  input  spf_pkg::conn_wr_t wr,
  input  logic [CIW-1:0]    waddr,
  input  logic [CIW-1:0]    raddr,
  output spf_pkg::tuple_t   rdata
);
  import spf_pkg::*;

  tuple_t mem [CONN_ENTRIES];

  // write port
  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[waddr] <= wr.tup;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// File: hdl/stateful_packet_filter.sv
// ---------------------------------------------------------------------------
// stateful_packet_filter
// first-match rule classifier with a connection table for tracked rules
// ---------------------------------------------------------------------------
// One item is taken at a time. A packet walks the rules of each hook it
// visits, reading and then checking each scanned slot; a rule that needs a
// tracked connection adds a walk through the connection table, reading and
// checking each stored entry, all through one compare unit on memories with
// one read port each. A rule write passes through S_DONE and a connection
// addition through S_ADD and S_DONE. The result sits in an output register,
// so the next item is taken while it waits.
module stateful_packet_filter #(
  parameter int RULE_SLOTS   = 16,
  parameter int CONN_ENTRIES = 256
) (
  input  logic                            clk,
  input  logic                            rst,
  // in tdata, from bit 0: rule_index, src_ip, dst_ip, src_port, dst_port,
  // protocol, tcp_flags, rule_stage, rule_verdict, rule_needs_conn, zero fill
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [spf_pkg::IN_DATA_W-1:0]   s_tdata,
  input  logic [1:0]                      s_tuser,    // req_type
  // out tdata, from bit 0: verdict, hit, hit_rule, is_local, dropped,
  // conn_added, zero fill
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [spf_pkg::OUT_DATA_W-1:0]  m_tdata,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic                            cfg_index,
  input  logic [7:0]                      cfg_data
);
  import spf_pkg::*;

  localparam int RIW = (RULE_SLOTS > 1) ? $clog2(RULE_SLOTS) : 1;
  localparam int RCW = $clog2(RULE_SLOTS + 1);
  localparam int CIW = (CONN_ENTRIES > 1) ? $clog2(CONN_ENTRIES) : 1;
  localparam int CUW = $clog2(CONN_ENTRIES + 1);

  // input fields
  logic [3:0]  in_rule_index;
  tuple_t      in_tup;
  logic [7:0]  in_flags;
  logic [2:0]  in_stage;
  logic [2:0]  in_verdict;
  logic        in_needs;

  assign in_rule_index     = s_tdata[3:0];
  assign in_tup.src_ip     = s_tdata[35:4];
  assign in_tup.dst_ip     = s_tdata[67:36];
  assign in_tup.sport      = s_tdata[83:68];
  assign in_tup.dport      = s_tdata[99:84];
  assign in_tup.protocol   = s_tdata[107:100];
  assign in_flags          = s_tdata[115:108];
  assign in_stage          = s_tdata[118:116];
  assign in_verdict        = s_tdata[121:119];
  assign in_needs          = s_tdata[122];

  state_t state, state_next;
  phase_t phase, phase_next;

  logic [7:0]     local_threshold;
  logic [4:0]     rule_count;
  logic [CUW-1:0] conn_used, conn_used_next;

  tuple_t         pkt, pkt_next;
  logic [7:0]     pkt_flags, pkt_flags_next;
  logic [2:0]     stage_a, stage_a_next, stage_b, stage_b_next;
  logic           has_b, has_b_next, has_c, has_c_next;
  logic           is_loc, is_loc_next;
  logic [RCW-1:0] ri, ri_next;
  logic [CUW-1:0] ci, ci_next;
  logic [2:0]     res_verdict, res_verdict_next;
  logic           res_hit, res_hit_next;
  logic [3:0]     res_slot, res_slot_next;
  logic           added, added_next;

  logic           in_acc;
  assign in_acc    = s_tvalid && s_tready;
  assign s_tready  = (state == S_IDLE) && !rst;
  assign cfg_ready = !rst;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      local_threshold <= THRESHOLD_RESET;
      rule_count      <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_THRESHOLD:  local_threshold <= cfg_data;
        CFG_RULE_COUNT: rule_count      <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  // rule memory
  rule_t rule_mem [RULE_SLOTS];
  rule_t rule_q;
  rule_t rule_wdata;
  logic  rule_we;

  assign rule_we = in_acc && (s_tuser == REQ_RULE_WR) &&
                   (32'(in_rule_index) < RULE_SLOTS);
  assign rule_wdata.needs_conn = in_needs;
  assign rule_wdata.verdict    = (in_verdict > V_MAX) ? V_DROP : in_verdict;
  assign rule_wdata.stage      = in_stage;
  assign rule_wdata.tup        = in_tup;

  always_ff @(posedge clk) begin
    if (rule_we) begin
      rule_mem[RIW'(in_rule_index)] <= rule_wdata;
    end
  end

  always_ff @(posedge clk) begin
    rule_q <= rule_mem[ri[RIW-1:0]];
  end

  // connection table
  conn_wr_t conn_wr;
  tuple_t   conn_q;
  tuple_t   rev_tup;
  logic     conn_room;

  assign conn_room  = (32'(conn_used) < CONN_ENTRIES);
  assign conn_wr.we = (state == S_ADD) && conn_room;
  assign conn_wr.tup = pkt;

  spf_conn_table #(
    .CONN_ENTRIES(CONN_ENTRIES),
    .CIW(CIW)
  ) u_conn (
    .clk  (clk),
    .wr   (conn_wr),
    .waddr(conn_used[CIW-1:0]),
    .raddr(ci[CIW-1:0]),
    .rdata(conn_q)
  );

  assign rev_tup.src_ip   = pkt.dst_ip;
  assign rev_tup.dst_ip   = pkt.src_ip;
  assign rev_tup.sport    = pkt.dport;
  assign rev_tup.dport    = pkt.sport;
  assign rev_tup.protocol = pkt.protocol;

  // shared compare unit
  logic [RCW-1:0] n_scan;
  logic [2:0]     cur_stage;
  logic           rule_end, fields_ok, chk_pass, conn_end, conn_hit;
  logic           match_now, miss_end, go_b, go_c, want_add;
  logic [2:0]     fin_verdict;
  state_t         end_state;

  assign n_scan = (32'(rule_count) > RULE_SLOTS) ? RCW'(RULE_SLOTS) : RCW'(rule_count);
  assign cur_stage = (phase == PH_A) ? stage_a : (phase == PH_B) ? stage_b : HK_POST;
  assign rule_end = (ri >= n_scan);
  assign fields_ok =
    (rule_q.tup.protocol == 8'd0  || rule_q.tup.protocol == pkt.protocol) &&
    (rule_q.tup.dport    == 16'd0 || rule_q.tup.dport    == pkt.dport) &&
    (rule_q.tup.sport    == 16'd0 || rule_q.tup.sport    == pkt.sport) &&
    (rule_q.tup.src_ip   == 32'd0 || rule_q.tup.src_ip   == pkt.src_ip) &&
    (rule_q.tup.dst_ip   == 32'd0 || rule_q.tup.dst_ip   == pkt.dst_ip);
  assign chk_pass  = (rule_q.stage == cur_stage) && fields_ok;
  assign conn_end  = (ci >= conn_used);
  assign conn_hit  = (conn_q == rev_tup);
  assign match_now = ((state == S_RULE_CHK) && chk_pass && !rule_q.needs_conn) ||
                     ((state == S_CONN_CHK) && conn_hit);
  assign miss_end  = (state == S_RULE_RD) && rule_end;
  assign fin_verdict = match_now ? rule_q.verdict : V_ACCEPT;
  assign go_b = miss_end && (phase == PH_A) && has_b;
  assign go_c = !go_b && has_c && (phase != PH_C) && (fin_verdict == V_ACCEPT);
  assign want_add = is_loc && (fin_verdict != V_DROP) &&
                    (pkt.protocol == PROTO_TCP) && pkt_flags[ACK_BIT];
  assign end_state = (go_b || go_c) ? S_RULE_RD : (want_add ? S_ADD : S_DONE);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_acc) begin
          case (s_tuser)
            REQ_RULE_WR:  state_next = S_DONE;
            REQ_CONN_ADD: state_next = S_ADD;
            default:      state_next = S_RULE_RD;
          endcase
        end
      end
      S_RULE_RD:  state_next = rule_end ? end_state : S_RULE_CHK;
      S_RULE_CHK: begin
        if (chk_pass && rule_q.needs_conn) begin
          state_next = S_CONN_RD;
        end else if (match_now) begin
          state_next = end_state;
        end else begin
          state_next = S_RULE_RD;
        end
      end
      S_CONN_RD:  state_next = conn_end ? S_RULE_RD : S_CONN_CHK;
      S_CONN_CHK: state_next = conn_hit ? end_state : S_CONN_RD;
      S_ADD:      state_next = S_DONE;
      S_DONE: begin
        if (!m_tvalid || m_tready) begin
          state_next = S_IDLE;
        end
      end
      default:    state_next = S_IDLE;
    endcase
  end

  // datapath updates
  always_comb begin
    phase_next       = phase;
    pkt_next         = pkt;
    pkt_flags_next   = pkt_flags;
    stage_a_next     = stage_a;
    stage_b_next     = stage_b;
    has_b_next       = has_b;
    has_c_next       = has_c;
    is_loc_next      = is_loc;
    ri_next          = ri;
    ci_next          = ci;
    res_verdict_next = res_verdict;
    res_hit_next     = res_hit;
    res_slot_next    = res_slot;
    added_next       = added;
    conn_used_next   = conn_used;
    case (state)
      S_IDLE: begin
        if (in_acc) begin
          pkt_next         = in_tup;
          pkt_flags_next   = in_flags;
          phase_next       = PH_A;
          ri_next          = '0;
          res_verdict_next = V_ACCEPT;
          res_hit_next     = 1'b0;
          res_slot_next    = 4'd0;
          added_next       = 1'b0;
          is_loc_next      = (s_tuser == REQ_PKT_IN) &&
                             (in_tup.dst_ip[7:0] > local_threshold);
          stage_a_next     = (s_tuser == REQ_PKT_OUT) ? HK_OUT : HK_PRE;
          if (in_tup.dst_ip[7:0] > local_threshold) begin
            stage_b_next = HK_IN;
          end else begin
            stage_b_next = HK_FWD;
          end
          has_b_next = (s_tuser == REQ_PKT_IN);
          has_c_next = (s_tuser == REQ_PKT_OUT) ||
                       !(in_tup.dst_ip[7:0] > local_threshold);
        end
      end
      S_RULE_RD: begin
        if (rule_end) begin
          ri_next = '0;
          if (go_b) begin
            phase_next = PH_B;
          end else if (go_c) begin
            phase_next = PH_C;
          end
        end
      end
      S_RULE_CHK: begin
        if (chk_pass && rule_q.needs_conn) begin
          ci_next = '0;
        end else if (!match_now) begin
          ri_next = ri + 1'b1;
        end
      end
      S_CONN_RD: begin
        if (conn_end) begin
          ri_next = ri + 1'b1;
        end
      end
      S_CONN_CHK: begin
        if (!conn_hit) begin
          ci_next = ci + 1'b1;
        end
      end
      S_ADD: begin
        if (conn_room) begin
          conn_used_next = conn_used + 1'b1;
          added_next     = 1'b1;
        end
      end
      default: ;
    endcase

    // a match closes the traversal; an accept may open post-routing
    if (match_now) begin
      if (go_c) begin
        res_verdict_next = V_ACCEPT;
        res_hit_next     = 1'b0;
        res_slot_next    = 4'd0;
        phase_next       = PH_C;
        ri_next          = '0;
      end else begin
        res_verdict_next = rule_q.verdict;
        res_hit_next     = 1'b1;
        res_slot_next    = 4'(ri);
      end
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      conn_used <= '0;
    end else begin
      state     <= state_next;
      conn_used <= conn_used_next;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    phase       <= phase_next;
    pkt         <= pkt_next;
    pkt_flags   <= pkt_flags_next;
    stage_a     <= stage_a_next;
    stage_b     <= stage_b_next;
    has_b       <= has_b_next;
    has_c       <= has_c_next;
    is_loc      <= is_loc_next;
    ri          <= ri_next;
    ci          <= ci_next;
    res_verdict <= res_verdict_next;
    res_hit     <= res_hit_next;
    res_slot    <= res_slot_next;
    added       <= added_next;
  end

  // output register
  logic out_load;
  assign out_load = (state == S_DONE) && (!m_tvalid || m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= {5'd0, added, (res_verdict == V_DROP), is_loc,
                  res_slot, res_hit, res_verdict};
    end
  end

endmodule

// File: hdl/spf_checker.sv
// ---------------------------------------------------------------------------
// spf_checker
// port-level checks of the stateful packet filter
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module spf_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_tvalid,
  input logic                            s_tready,
  input logic                            m_tvalid,
  input logic                            m_tready,
  input logic [spf_pkg::OUT_DATA_W-1:0]  m_tdata
);
  import spf_pkg::*;

  // a waiting result holds
  `ASSERT_NEXT(a_out_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

  // dropped flag follows the verdict
  `ASSERT_SAME(a_drop_flag, clk, rst, m_tvalid, m_tdata[9] == (m_tdata[2:0] == V_DROP))

  // no slot without a hit
  `ASSERT_SAME(a_slot_hit, clk, rst, m_tvalid && !m_tdata[3], m_tdata[7:4] == 4'd0)

  // one item at a time
  `ASSERT_NEXT(a_busy, clk, rst, s_tvalid && s_tready, !s_tready)

endmodule

bind stateful_packet_filter spf_checker u_spf_checker (
  .clk     (clk),
  .rst     (rst),
  .s_tvalid(s_tvalid),
  .s_tready(s_tready),
  .m_tvalid(m_tvalid),
  .m_tready(m_tready),
  .m_tdata (m_tdata)
);
